/* hw/rtl/gpioirq_pkg.sv */
// Package for the GPIO port with interrupt detection.
// Holds the transfer payload types, action and register codes, and config word layout.
// No dependencies.
`default_nettype none

package gpioirq_pkg;

  // Action codes; the fourth code of the field is invalid.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  // Register codes; the eighth code of the field is invalid.
  localparam logic [2:0] REG_CONFIG   = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE = 3'd1;
  localparam logic [2:0] REG_INPUT    = 3'd2;
  localparam logic [2:0] REG_FLOAT    = 3'd3;
  localparam logic [2:0] REG_OUTVAL   = 3'd4;
  localparam logic [2:0] REG_IRQCLR   = 3'd5;
  localparam logic [2:0] REG_STATUS   = 3'd6;
  localparam logic [2:0] REG_INVALID  = 3'd7;

  // Pin config word layout.
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned CFG_ENABLE_BIT = 0;
  localparam int unsigned CFG_OUT_BIT    = 1;
  localparam int unsigned CFG_TYPE_LSB   = 2;
  localparam int unsigned CFG_POL_BIT    = 4;
  localparam int unsigned CFG_IRQ_EN_BIT = 6;

  // Trigger types.
  localparam logic [1:0] TRIG_NONE   = 2'd0;
  localparam logic [1:0] TRIG_LEVEL  = 2'd1;
  localparam logic [1:0] TRIG_SINGLE = 2'd2;
  localparam logic [1:0] TRIG_DOUBLE = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] pin_index;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] pad_levels;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] pad_drive;
    logic [7:0] pad_drive_enable;
    logic       irq_line;
    logic       bad_access;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/gpio_port_with_irq_detect.sv */
// Channel  | Direction | Payload            | Handshake
// in       | input     | gpioirq_pkg::in_t  | in_valid_i / in_stall_o
// out      | output    | gpioirq_pkg::out_t | out_valid_o / out_stall_i
//
// Each item passes through an input register, then the register bank updates and the
// result is captured in the output register, one item per cycle without output stalls.
// Reset clears both pipeline valids and puts every pin in the disabled, floated state.
// A stall on the output holds the output register; the input register keeps accepting
// until it too is full, so the throughput stays one transfer per cycle without stalls.
// Top level: input and output pipeline registers around gpioirq_regs.
`default_nettype none

module gpio_port_with_irq_detect #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gpioirq_pkg::in_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gpioirq_pkg::out_t      out_o
);

  logic              in_valid_q;
  gpioirq_pkg::in_t  in_q;
  logic              out_valid_q;
  gpioirq_pkg::out_t out_q;
  gpioirq_pkg::out_t result;
  logic              advance;
  logic              fire;

  // The output register can take a new result when empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  gpioirq_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* hw/rtl/gpioirq_detect.sv */
// Per-pin interrupt event detection for one pad sample.
// Depends on gpioirq_pkg for the config word layout and trigger types.
`default_nettype none

module gpioirq_detect #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  wire logic [PIN_COUNT-1:0][gpioirq_pkg::CFG_W-1:0] cfg_i,
  input  wire logic [PIN_COUNT-1:0]                         old_levels_i,
  input  wire logic [PIN_COUNT-1:0]                         new_levels_i,
  output logic      [PIN_COUNT-1:0]                         events_o
);

  always_comb begin
    logic [1:0] trig;
    logic       pol;
    logic       changed;
    events_o = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      trig    = cfg_i[i][gpioirq_pkg::CFG_TYPE_LSB +: 2];
      pol     = cfg_i[i][gpioirq_pkg::CFG_POL_BIT];
      changed = old_levels_i[i] ^ new_levels_i[i];
      if (cfg_i[i][gpioirq_pkg::CFG_ENABLE_BIT]) begin
        unique case (trig)
          gpioirq_pkg::TRIG_LEVEL:  events_o[i] = (new_levels_i[i] == pol);
          gpioirq_pkg::TRIG_SINGLE: events_o[i] = changed && (new_levels_i[i] == pol);
          gpioirq_pkg::TRIG_DOUBLE: events_o[i] = changed;
          default:                  events_o[i] = 1'b0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gpioirq_regs.sv */
// Per-pin register set, pad level history and pending mask, with the read mux.
// Depends on gpioirq_pkg and instantiates gpioirq_detect.
`default_nettype none

module gpioirq_regs #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire gpioirq_pkg::in_t  item_i,
  output gpioirq_pkg::out_t      result_o
);

  localparam int unsigned CW = gpioirq_pkg::CFG_W;

  logic [PIN_COUNT-1:0][CW-1:0] cfg_q, cfg_d;
  logic [PIN_COUNT-1:0][7:0]    deb_q, deb_d;
  logic [PIN_COUNT-1:0]         float_q, float_d;
  logic [PIN_COUNT-1:0]         drive_q, drive_d;
  logic [PIN_COUNT-1:0]         last_q, last_d;
  logic [PIN_COUNT-1:0]         pend_q, pend_d;
  logic [PIN_COUNT-1:0]         events;
  logic [PIN_COUNT-1:0]         now_levels;

  logic       bad;
  logic       pin_ok;
  logic       is_wr;
  logic       is_rd;
  logic       is_smp;
  logic [7:0] rd_data;

  assign now_levels = item_i.pad_levels[PIN_COUNT-1:0];

  gpioirq_detect #(
    .PIN_COUNT(PIN_COUNT)
  ) u_detect (
    .cfg_i       (cfg_q),
    .old_levels_i(last_q),
    .new_levels_i(now_levels),
    .events_o    (events)
  );

  assign bad = (item_i.action != gpioirq_pkg::ACT_WRITE &&
                item_i.action != gpioirq_pkg::ACT_READ &&
                item_i.action != gpioirq_pkg::ACT_SAMPLE) ||
               (item_i.action != gpioirq_pkg::ACT_SAMPLE &&
                item_i.reg_index == gpioirq_pkg::REG_INVALID);
  assign pin_ok = {1'b0, item_i.pin_index} < 4'(PIN_COUNT);
  assign is_wr  = !bad && item_i.action == gpioirq_pkg::ACT_WRITE && pin_ok;
  assign is_rd  = !bad && item_i.action == gpioirq_pkg::ACT_READ;
  assign is_smp = item_i.action == gpioirq_pkg::ACT_SAMPLE;

  // Next state; the result reflects the state after this item.
  always_comb begin
    logic sel;
    cfg_d   = cfg_q;
    deb_d   = deb_q;
    float_d = float_q;
    drive_d = drive_q;
    last_d  = is_smp ? now_levels : last_q;
    pend_d  = is_smp ? (pend_q | events) : pend_q;
    for (int i = 0; i < PIN_COUNT; i++) begin
      sel = is_wr && (item_i.pin_index == 3'(i));
      if (sel) begin
        unique case (item_i.reg_index)
          gpioirq_pkg::REG_CONFIG:   cfg_d[i]   = item_i.write_data[CW-1:0];
          gpioirq_pkg::REG_DEBOUNCE: deb_d[i]   = item_i.write_data;
          gpioirq_pkg::REG_FLOAT:    float_d[i] = item_i.write_data[0];
          gpioirq_pkg::REG_OUTVAL:   drive_d[i] = item_i.write_data[0];
          gpioirq_pkg::REG_IRQCLR: begin
            if (item_i.write_data[0]) begin
              pend_d[i] = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Read mux over the current state.
  always_comb begin
    logic [7:0] pin_val;
    pin_val = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (item_i.pin_index == 3'(i)) begin
        unique case (item_i.reg_index)
          gpioirq_pkg::REG_CONFIG:   pin_val = 8'(cfg_q[i]);
          gpioirq_pkg::REG_DEBOUNCE: pin_val = deb_q[i];
          gpioirq_pkg::REG_INPUT:    pin_val = 8'(last_q[i]);
          gpioirq_pkg::REG_FLOAT:    pin_val = 8'(float_q[i]);
          gpioirq_pkg::REG_OUTVAL:   pin_val = 8'(drive_q[i]);
          default:                   pin_val = '0;
        endcase
      end
    end
    if (!is_rd) begin
      rd_data = '0;
    end else if (item_i.reg_index == gpioirq_pkg::REG_STATUS) begin
      rd_data = 8'(pend_q);
    end else begin
      rd_data = pin_val;
    end
  end

  always_comb begin
    logic [PIN_COUNT-1:0] den;
    logic [PIN_COUNT-1:0] irq_bits;
    for (int i = 0; i < PIN_COUNT; i++) begin
      den[i] = cfg_d[i][gpioirq_pkg::CFG_ENABLE_BIT] &&
               cfg_d[i][gpioirq_pkg::CFG_OUT_BIT] && !float_d[i];
      irq_bits[i] = cfg_d[i][gpioirq_pkg::CFG_IRQ_EN_BIT] && pend_d[i];
    end
    result_o.read_data        = rd_data;
    result_o.pad_drive        = 8'(drive_d);
    result_o.pad_drive_enable = 8'(den);
    result_o.irq_line         = |irq_bits;
    result_o.bad_access       = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      deb_q   <= '0;
      float_q <= '1;
      drive_q <= '0;
      last_q  <= '0;
      pend_q  <= '0;
    end else if (fire_i) begin
      cfg_q   <= cfg_d;
      deb_q   <= deb_d;
      float_q <= float_d;
      drive_q <= drive_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_gpio_port_with_irq_detect.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gpio_port_with_irq_detect: a queue-fed driver, a monitor and a
// cycle-free predictor of the pin register bank and interrupt detection.
// Depends on gpioirq_pkg and the gpio_port_with_irq_detect top level.

module tb_gpio_port_with_irq_detect;

  localparam int unsigned PINS = 8;
  localparam logic [7:0] PORT_MASK = (PINS >= 8) ? 8'hFF : 8'((1 << PINS) - 1);
  localparam logic [1:0] ACT_INVALID = 2'd3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned N_RANDOM = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  gpioirq_pkg::in_t in_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  gpioirq_pkg::out_t out_o;

  gpio_port_with_irq_detect #(
    .PIN_COUNT(PINS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // Predicted register bank and detection state.
  logic [gpioirq_pkg::CFG_W-1:0] pin_cfg [8] = '{default: '0};
  logic [7:0] debounce_val [8] = '{default: '0};
  logic [7:0] floated = 8'hFF;
  logic [7:0] drive_bits = 8'h00;
  logic [7:0] seen_levels = 8'h00;
  logic [7:0] pending_irqs = 8'h00;

  gpioirq_pkg::in_t gpio_items [$];
  gpioirq_pkg::out_t gpio_expect [$];
  int n_sent = 0;
  int n_recv = 0;
  int n_fail = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one item to the predicted state and returns the result it should produce.
  function automatic gpioirq_pkg::out_t predict_gpio(gpioirq_pkg::in_t it);
    gpioirq_pkg::out_t r;
    logic [gpioirq_pkg::CFG_W-1:0] c;
    logic [7:0] now_lv;
    logic [7:0] hits;
    logic n;
    logic o;
    r = '0;
    hits = '0;
    if (it.action == ACT_INVALID ||
        (it.action != gpioirq_pkg::ACT_SAMPLE &&
         it.reg_index == gpioirq_pkg::REG_INVALID)) begin
      r.bad_access = 1'b1;
    end else if (it.action == gpioirq_pkg::ACT_WRITE) begin
      if (it.pin_index < PINS) begin
        case (it.reg_index)
          gpioirq_pkg::REG_CONFIG:
            pin_cfg[it.pin_index] = it.write_data[gpioirq_pkg::CFG_W-1:0];
          gpioirq_pkg::REG_DEBOUNCE: debounce_val[it.pin_index] = it.write_data;
          gpioirq_pkg::REG_FLOAT:    floated[it.pin_index] = it.write_data[0];
          gpioirq_pkg::REG_OUTVAL:   drive_bits[it.pin_index] = it.write_data[0];
          gpioirq_pkg::REG_IRQCLR: begin
            if (it.write_data[0]) pending_irqs[it.pin_index] = 1'b0;
          end
          default: ;
        endcase
      end
    end else if (it.action == gpioirq_pkg::ACT_READ) begin
      if (it.reg_index == gpioirq_pkg::REG_STATUS) begin
        r.read_data = pending_irqs;
      end else if (it.pin_index < PINS) begin
        case (it.reg_index)
          gpioirq_pkg::REG_CONFIG:   r.read_data = 8'(pin_cfg[it.pin_index]);
          gpioirq_pkg::REG_DEBOUNCE: r.read_data = debounce_val[it.pin_index];
          gpioirq_pkg::REG_INPUT:    r.read_data = {7'd0, seen_levels[it.pin_index]};
          gpioirq_pkg::REG_FLOAT:    r.read_data = {7'd0, floated[it.pin_index]};
          gpioirq_pkg::REG_OUTVAL:   r.read_data = {7'd0, drive_bits[it.pin_index]};
          default:                   r.read_data = '0;
        endcase
      end
    end else begin
      now_lv = it.pad_levels & PORT_MASK;
      for (int i = 0; i < PINS; i++) begin
        c = pin_cfg[i];
        n = now_lv[i];
        o = seen_levels[i];
        if (c[gpioirq_pkg::CFG_ENABLE_BIT]) begin
          case (c[gpioirq_pkg::CFG_TYPE_LSB +: 2])
            gpioirq_pkg::TRIG_LEVEL:  hits[i] = (n == c[gpioirq_pkg::CFG_POL_BIT]);
            gpioirq_pkg::TRIG_SINGLE:
              hits[i] = (n != o) && (n == c[gpioirq_pkg::CFG_POL_BIT]);
            gpioirq_pkg::TRIG_DOUBLE: hits[i] = (n != o);
            default: ;
          endcase
        end
      end
      pending_irqs = (pending_irqs | hits) & PORT_MASK;
      seen_levels = now_lv;
    end
    for (int i = 0; i < PINS; i++) begin
      c = pin_cfg[i];
      r.pad_drive[i] = drive_bits[i];
      r.pad_drive_enable[i] = c[gpioirq_pkg::CFG_ENABLE_BIT] & c[gpioirq_pkg::CFG_OUT_BIT] &
                              ~floated[i];
      if (c[gpioirq_pkg::CFG_IRQ_EN_BIT] && pending_irqs[i]) r.irq_line = 1'b1;
    end
    return r;
  endfunction

  // Wait before the next transfer; every fourth stretch of items runs without idling.
  function automatic int pace(int count);
    if ((count / 160) % 4 == 1) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic gpioirq_pkg::in_t gpio_op(logic [1:0] act, logic [2:0] pin,
                                               logic [2:0] rg, logic [7:0] data,
                                               logic [7:0] pads);
    gpioirq_pkg::in_t it;
    it.action = act;
    it.pin_index = pin;
    it.reg_index = rg;
    it.write_data = data;
    it.pad_levels = pads;
    return it;
  endfunction

  function automatic logic [7:0] cfg_word(logic en, logic dir_out, logic [1:0] trig,
                                          logic pol, logic irq_en);
    logic [7:0] w;
    w = '0;
    w[gpioirq_pkg::CFG_ENABLE_BIT] = en;
    w[gpioirq_pkg::CFG_OUT_BIT] = dir_out;
    w[gpioirq_pkg::CFG_TYPE_LSB +: 2] = trig;
    w[gpioirq_pkg::CFG_POL_BIT] = pol;
    w[gpioirq_pkg::CFG_IRQ_EN_BIT] = irq_en;
    return w;
  endfunction

  task automatic cmp_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, fname, exp_v, got_v);
      n_fail++;
    end
  endtask

  task automatic check_result(gpioirq_pkg::out_t got);
    gpioirq_pkg::out_t exp_r;
    if (gpio_expect.size() == 0) begin
      $display("%0t: result transfer expected none, got %p", $time, got);
      n_fail++;
    end else begin
      exp_r = gpio_expect.pop_front();
      cmp_field("read_data", exp_r.read_data, got.read_data);
      cmp_field("pad_drive", exp_r.pad_drive, got.pad_drive);
      cmp_field("pad_drive_enable", exp_r.pad_drive_enable, got.pad_drive_enable);
      cmp_field("irq_line", 8'(exp_r.irq_line), 8'(got.irq_line));
      cmp_field("bad_access", 8'(exp_r.bad_access), 8'(got.bad_access));
    end
  endtask

  // Driver: the expectation is computed at the edge where the input transfer happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall_o) begin
      if (in_valid) begin
        gpio_expect.push_back(predict_gpio(in_i));
        n_sent <= n_sent + 1;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (gpio_items.size() != 0) begin
        in_i <= gpio_items.pop_front();
        in_valid <= 1'b1;
        gap_left <= pace(n_sent);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and draws the stall that precedes the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      check_result(out_o);
      n_recv <= n_recv + 1;
      w = pace(n_recv);
      stall_left <= w;
      out_stall_i <= (w != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    logic [7:0] pads;
    logic [7:0] wd;
    int pick;
    // Directed part: reset values, every trigger type, read-only and invalid targets.
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd7, gpioirq_pkg::REG_FLOAT,
                                 8'hFF, 8'hFF));
    // A disabled port still records levels; the first sample compares against zero.
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'hFF));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd7, gpioirq_pkg::REG_INPUT,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 cfg_word(1'b1, 1'b0, gpioirq_pkg::TRIG_LEVEL, 1'b1, 1'b1),
                                 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h01));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd0, gpioirq_pkg::REG_IRQCLR,
                                 8'hFE, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd0, gpioirq_pkg::REG_IRQCLR,
                                 8'h01, 8'h00));
    // The held level sets the pending bit again.
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_INVALID,
                                 8'h00, 8'h01));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd1, gpioirq_pkg::REG_CONFIG,
                                 cfg_word(1'b1, 1'b1, gpioirq_pkg::TRIG_SINGLE, 1'b1, 1'b1),
                                 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd1, gpioirq_pkg::REG_FLOAT,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd1, gpioirq_pkg::REG_OUTVAL,
                                 8'h01, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h03));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd2, gpioirq_pkg::REG_CONFIG,
                                 cfg_word(1'b1, 1'b0, gpioirq_pkg::TRIG_DOUBLE, 1'b0, 1'b1),
                                 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h07));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h03));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd3, gpioirq_pkg::REG_DEBOUNCE,
                                 8'hFF, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd3, gpioirq_pkg::REG_DEBOUNCE,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd4, gpioirq_pkg::REG_CONFIG,
                                 8'hFF, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd4, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h00));
    // Writes to read-only registers are dropped without an error.
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd5, gpioirq_pkg::REG_INPUT,
                                 8'hFF, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd6, gpioirq_pkg::REG_STATUS,
                                 8'hFF, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd6, gpioirq_pkg::REG_STATUS,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd0, gpioirq_pkg::REG_IRQCLR,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(ACT_INVALID, 3'd7, gpioirq_pkg::REG_STATUS, 8'hFF, 8'hFF));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd0, gpioirq_pkg::REG_INVALID,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd0, gpioirq_pkg::REG_INVALID,
                                 8'h00, 8'h00));
    // Disabling a pin keeps what it already has pending.
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'd0, gpioirq_pkg::REG_CONFIG,
                                 8'h00, 8'h00));
    gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'd0, gpioirq_pkg::REG_STATUS,
                                 8'h00, 8'h00));

    // Random part: mostly configuration writes and pad samples that walk the pads a bit
    // at a time, so that levels hold and edges land on configured pins.
    pads = 8'h00;
    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      wd = 8'($urandom());
      if (pick < 14) begin
        if ($urandom_range(0, 3) != 0) wd[gpioirq_pkg::CFG_ENABLE_BIT] = 1'b1;
        gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'($urandom()),
                                     gpioirq_pkg::REG_CONFIG, wd, 8'($urandom())));
      end else if (pick < 24) begin
        gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'($urandom()),
                                     3'($urandom()), wd, 8'($urandom())));
      end else if (pick < 31) begin
        gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_WRITE, 3'($urandom()),
                                     gpioirq_pkg::REG_IRQCLR, wd, 8'($urandom())));
      end else if (pick < 46) begin
        gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_READ, 3'($urandom()),
                                     3'($urandom()), wd, 8'($urandom())));
      end else if (pick < 97) begin
        if ($urandom_range(0, 1) == 0) pads[$urandom_range(0, 7)] ^= 1'b1;
        else if ($urandom_range(0, 3) == 0) pads = 8'($urandom());
        gpio_items.push_back(gpio_op(gpioirq_pkg::ACT_SAMPLE, 3'($urandom()),
                                     3'($urandom()), wd, pads));
      end else begin
        gpio_items.push_back(gpio_op(ACT_INVALID, 3'($urandom()), 3'($urandom()), wd,
                                     8'($urandom())));
      end
    end

    wait (rst_ni);
    while (gpio_items.size() != 0 || in_valid || gpio_expect.size() != 0) @(negedge clk_i);
    // Two pipeline stages; leave room for any stray result.
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
